### rtl/core/ppkcc_pkg.sv
// Package for the pulsed potassium channel current unit.
// Holds shared constants, register indexes, control types and the microcode program.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppkcc_pkg;

    // Defaults for the top-level parameters
    localparam int TIME_WIDTH_DEF = 32;
    localparam int EXP_DEPTH_DEF  = 256;

    // Fixed-point one in Q1.15
    localparam logic [15:0] ONE_Q15 = 16'h8000;

    // Configuration register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_GAIN       = 3'd0;
    localparam logic [2:0] REG_RISE_RATE  = 3'd1;
    localparam logic [2:0] REG_DECAY_RATE = 3'd2;
    localparam logic [2:0] REG_FIRE_LEVEL = 3'd3;
    localparam logic [2:0] REG_OPEN_DUR   = 3'd4;
    localparam logic [2:0] REG_REFRACTORY = 3'd5;
    localparam logic [2:0] REG_REVERSAL   = 3'd6;

    localparam int PC_W = 4;

    // Multiplier operand A selects
    localparam logic [2:0] A_ZERO = 3'd0;
    localparam logic [2:0] A_RATE = 3'd1;
    localparam logic [2:0] A_X    = 3'd2;
    localparam logic [2:0] A_QD   = 3'd3;
    localparam logic [2:0] A_Q    = 3'd4;
    localparam logic [2:0] A_GAIN = 3'd5;
    localparam logic [2:0] A_GQ   = 3'd6;

    // Multiplier operand B selects
    localparam logic [2:0] B_ZERO  = 3'd0;
    localparam logic [2:0] B_DT    = 3'd1;
    localparam logic [2:0] B_DEPTH = 3'd2;
    localparam logic [2:0] B_E     = 3'd3;
    localparam logic [2:0] B_Q     = 3'd4;
    localparam logic [2:0] B_QQ    = 3'd5;
    localparam logic [2:0] B_DIFF  = 3'd6;

    // Write-back operations
    localparam logic [3:0] WB_NONE = 4'd0;
    localparam logic [3:0] WB_LOAD = 4'd1;
    localparam logic [3:0] WB_X    = 4'd2;
    localparam logic [3:0] WB_IDX  = 4'd3;
    localparam logic [3:0] WB_E    = 4'd4;
    localparam logic [3:0] WB_Q    = 4'd5;
    localparam logic [3:0] WB_QQ   = 4'd6;
    localparam logic [3:0] WB_G    = 4'd7;
    localparam logic [3:0] WB_CUR  = 4'd8;
    localparam logic [3:0] WB_OUT  = 4'd9;

    // Jump conditions: hold in place while the condition is pending, else go to target
    localparam logic [1:0] JC_NEXT     = 2'd0;
    localparam logic [1:0] JC_HOLD_IN  = 2'd1;
    localparam logic [1:0] JC_HOLD_OUT = 2'd2;

    typedef struct packed {
        logic [23:0]        gain;
        logic [15:0]        rise_rate;
        logic [15:0]        decay_rate;
        logic signed [15:0] fire_level;
        logic [23:0]        open_duration;
        logic [23:0]        refractory_time;
        logic signed [15:0] reversal_level;
    } t_cfg;

    typedef struct packed {
        logic [2:0]      a_sel;
        logic [2:0]      b_sel;
        logic [3:0]      wb;
        logic [1:0]      jc;
        logic [PC_W-1:0] target;
    } t_ucode;

    typedef struct packed {
        t_ucode uc;
        logic   go;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic out_busy;
    } t_seq_stat;

    // Microcode program: one control word per step
    function automatic t_ucode ucode_rom(input logic [PC_W-1:0] pc);
        t_ucode w;
        w = '{a_sel: A_ZERO, b_sel: B_ZERO, wb: WB_NONE, jc: JC_NEXT, target: '0};
        case (pc)
            4'd0: w = '{a_sel: A_ZERO, b_sel: B_ZERO,  wb: WB_LOAD, jc: JC_HOLD_IN,  target: 4'd1};
            4'd1: w = '{a_sel: A_RATE, b_sel: B_DT,    wb: WB_X,    jc: JC_NEXT,     target: 4'd2};
            4'd2: w = '{a_sel: A_X,    b_sel: B_DEPTH, wb: WB_IDX,  jc: JC_NEXT,     target: 4'd3};
            4'd3: w = '{a_sel: A_ZERO, b_sel: B_ZERO,  wb: WB_NONE, jc: JC_NEXT,     target: 4'd4};
            4'd4: w = '{a_sel: A_ZERO, b_sel: B_ZERO,  wb: WB_E,    jc: JC_NEXT,     target: 4'd5};
            4'd5: w = '{a_sel: A_QD,   b_sel: B_E,     wb: WB_Q,    jc: JC_NEXT,     target: 4'd6};
            4'd6: w = '{a_sel: A_Q,    b_sel: B_Q,     wb: WB_QQ,   jc: JC_NEXT,     target: 4'd7};
            4'd7: w = '{a_sel: A_GAIN, b_sel: B_QQ,    wb: WB_G,    jc: JC_NEXT,     target: 4'd8};
            4'd8: w = '{a_sel: A_GQ,   b_sel: B_DIFF,  wb: WB_CUR,  jc: JC_NEXT,     target: 4'd9};
            4'd9: w = '{a_sel: A_ZERO, b_sel: B_ZERO,  wb: WB_OUT,  jc: JC_HOLD_OUT, target: 4'd0};
            default: w = '{a_sel: A_ZERO, b_sel: B_ZERO, wb: WB_NONE, jc: JC_NEXT, target: 4'd0};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

### rtl/core/ppkcc_exp_rom.sv
// Exponential decay ROM: entry k holds round(2^15 * r^k), r = exp(-16/DEPTH).
// Table is built at elaboration; read data is registered. No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module ppkcc_exp_rom #(
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    output logic [15:0]                   o_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int ENTRIES = 1 << AW;
    // Step of the table argument in Q30: 16 / DEPTH
    localparam longint ExpStep = 64'sd17179869184 / DEPTH;
    localparam longint One30   = 64'sd1073741824;

    // Taylor terms of exp(-step) in Q30, each from the one before
    localparam longint Term01 = (One30 * ExpStep) >>> 30;
    localparam longint Term02 = ((Term01 * ExpStep) >>> 30) / 2;
    localparam longint Term03 = ((Term02 * ExpStep) >>> 30) / 3;
    localparam longint Term04 = ((Term03 * ExpStep) >>> 30) / 4;
    localparam longint Term05 = ((Term04 * ExpStep) >>> 30) / 5;
    localparam longint Term06 = ((Term05 * ExpStep) >>> 30) / 6;
    localparam longint Term07 = ((Term06 * ExpStep) >>> 30) / 7;
    localparam longint Term08 = ((Term07 * ExpStep) >>> 30) / 8;
    localparam longint Term09 = ((Term08 * ExpStep) >>> 30) / 9;
    localparam longint Term10 = ((Term09 * ExpStep) >>> 30) / 10;
    localparam longint Term11 = ((Term10 * ExpStep) >>> 30) / 11;
    localparam longint Term12 = ((Term11 * ExpStep) >>> 30) / 12;
    localparam longint Term13 = ((Term12 * ExpStep) >>> 30) / 13;
    localparam longint Term14 = ((Term13 * ExpStep) >>> 30) / 14;
    localparam longint Term15 = ((Term14 * ExpStep) >>> 30) / 15;
    localparam longint Term16 = ((Term15 * ExpStep) >>> 30) / 16;
    localparam longint Term17 = ((Term16 * ExpStep) >>> 30) / 17;
    localparam longint Term18 = ((Term17 * ExpStep) >>> 30) / 18;
    localparam longint Term19 = ((Term18 * ExpStep) >>> 30) / 19;
    localparam longint Term20 = ((Term19 * ExpStep) >>> 30) / 20;
    localparam longint Term21 = ((Term20 * ExpStep) >>> 30) / 21;
    localparam longint Term22 = ((Term21 * ExpStep) >>> 30) / 22;
    localparam longint Term23 = ((Term22 * ExpStep) >>> 30) / 23;
    localparam longint Term24 = ((Term23 * ExpStep) >>> 30) / 24;

    // Alternating sum, clamped to [0, 1]
    localparam longint SeriesSum = One30 - Term01 + Term02 - Term03 + Term04
                                 - Term05 + Term06 - Term07 + Term08 - Term09
                                 + Term10 - Term11 + Term12 - Term13 + Term14
                                 - Term15 + Term16 - Term17 + Term18 - Term19
                                 + Term20 - Term21 + Term22 - Term23 + Term24;
    localparam longint Ratio = (SeriesSum < 0) ? 64'sd0 :
                               ((SeriesSum > One30) ? One30 : SeriesSum);

    // Powers of the ratio with round half up
    function automatic logic [ENTRIES*16-1:0] build_tab();
        logic [ENTRIES*16-1:0] tab;
        longint acc;
        int k;
        tab = '0;
        acc = One30;
        for (k = 0; k < DEPTH; k++) begin
            tab[k*16 +: 16] = 16'((acc + 64'sd16384) >>> 15);
            acc = (acc * Ratio + 64'sd536870912) >>> 30;
        end
        return tab;
    endfunction

    localparam logic [ENTRIES*16-1:0] ExpTab = build_tab();

    // Registered read
    always_ff @(posedge i_clk) begin
        o_data <= ExpTab[i_addr*16 +: 16];
    end

endmodule

`default_nettype wire

### rtl/core/ppkcc_seq.sv
// Microcode sequencer: step counter, program ROM lookup and hold/jump control.
// Depends on ppkcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppkcc_seq (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire ppkcc_pkg::t_seq_stat i_stat,
    output ppkcc_pkg::t_ctrl          o_ctrl
);

    import ppkcc_pkg::*;

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_ucode          uc;
    logic            hold;

    // Fetch the control word for this step
    assign uc = ucode_rom(r_pc);

    // Stay on a waiting step until its condition clears
    always_comb begin
        case (uc.jc)
            JC_HOLD_IN:  hold = !i_stat.in_valid;
            JC_HOLD_OUT: hold = i_stat.out_busy;
            default:     hold = 1'b0;
        endcase
    end

    assign n_pc = hold ? r_pc : uc.target;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= '0;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl.uc = uc;
    assign o_ctrl.go = !hold;

endmodule

`default_nettype wire

### rtl/core/ppkcc_dp.sv
// Datapath: shared multiplier, working registers, gate state and exponential ROM.
// Depends on ppkcc_pkg and ppkcc_exp_rom; driven by the sequencer control word.
`timescale 1ns / 1ps
`default_nettype none

module ppkcc_dp #(
    parameter int TIME_WIDTH      = ppkcc_pkg::TIME_WIDTH_DEF,
    parameter int EXP_TABLE_DEPTH = ppkcc_pkg::EXP_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ppkcc_pkg::t_ctrl   i_ctrl,
    input  wire ppkcc_pkg::t_cfg    i_cfg,
    input  wire logic [31:0]        i_now_time,
    input  wire logic signed [15:0] i_membrane_level,
    output logic [31:0]             o_current,
    output logic [15:0]             o_gate,
    output logic                    o_phase_open
);

    import ppkcc_pkg::*;

    localparam int AW = $clog2(EXP_TABLE_DEPTH);

    // Working registers
    logic [TIME_WIDTH-1:0] r_now;
    logic [TIME_WIDTH-1:0] r_dt;
    logic signed [15:0]    r_v;
    logic [39:0]           r_acc;
    logic                  r_xbig;
    logic [15:0]           r_e;
    logic [15:0]           r_q;
    logic [31:0]           r_cur;

    // Gate state
    logic                  r_open;
    logic                  r_has;
    logic [15:0]           r_gate;
    logic [TIME_WIDTH-1:0] r_last;

    logic [TIME_WIDTH-1:0] now_w;
    logic [23:0]           dt_lo;
    logic                  dt_big;
    logic [15:0]           rate;
    logic [15:0]           q0;
    logic [15:0]           qd;
    logic [16:0]           diff;
    logic                  diff_neg;
    logic [15:0]           abs_diff;
    logic [32:0]           mul_a;
    logic [30:0]           mul_b;
    logic [63:0]           prod;
    logic [15:0]           rom_data;
    logic                  idx_big;
    logic [15:0]           e_sel;
    logic [15:0]           q_rnd;
    logic [33:0]           mag;
    logic [31:0]           cur_sat;
    logic                  inf;
    logic                  dt_gt_open;
    logic                  dt_gt_refr;
    logic                  do_switch;
    logic                  wb_go;

    assign wb_go = i_ctrl.go;

    // Time and gate helpers
    assign now_w      = TIME_WIDTH'(i_now_time);
    assign dt_lo      = 24'(r_dt);
    assign dt_big     = (r_dt >> 24) != '0;
    assign rate       = r_open ? i_cfg.rise_rate : i_cfg.decay_rate;
    assign q0         = (r_gate > ONE_Q15) ? ONE_Q15 : r_gate;
    assign qd         = r_open ? (ONE_Q15 - q0) : q0;
    assign inf        = !r_has;
    assign dt_gt_open = 64'(r_dt) > 64'(i_cfg.open_duration);
    assign dt_gt_refr = 64'(r_dt) > 64'(i_cfg.refractory_time);

    // Reversal minus membrane, as sign and magnitude
    assign diff     = {i_cfg.reversal_level[15], i_cfg.reversal_level} - {r_v[15], r_v};
    assign diff_neg = diff[16];
    assign abs_diff = diff_neg ? 16'(-diff) : 16'(diff);

    // Shared multiplier operands
    always_comb begin
        case (i_ctrl.uc.a_sel)
            A_RATE:  mul_a = 33'(rate);
            A_X:     mul_a = 33'(r_acc[23:0]);
            A_QD:    mul_a = 33'(qd);
            A_Q:     mul_a = 33'(r_q);
            A_GAIN:  mul_a = 33'(i_cfg.gain);
            A_GQ:    mul_a = r_acc[32:0];
            default: mul_a = '0;
        endcase
    end

    always_comb begin
        case (i_ctrl.uc.b_sel)
            B_DT:    mul_b = 31'(dt_lo);
            B_DEPTH: mul_b = 31'(EXP_TABLE_DEPTH);
            B_E:     mul_b = 31'(r_e);
            B_Q:     mul_b = 31'(r_q);
            B_QQ:    mul_b = r_acc[30:0];
            B_DIFF:  mul_b = 31'(abs_diff);
            default: mul_b = '0;
        endcase
    end

    assign prod = 64'(mul_a) * 64'(mul_b);

    // Exponential table lookup, address from the rounded index
    ppkcc_exp_rom #(
        .DEPTH (EXP_TABLE_DEPTH)
    ) u_exp_rom (
        .i_clk  (i_clk),
        .i_addr (r_acc[AW-1:0]),
        .o_data (rom_data)
    );

    assign idx_big = r_acc >= 40'(EXP_TABLE_DEPTH);

    // exp(-x): never switched gives 0, zero rate gives one, out of range gives 0
    always_comb begin
        if (inf) begin
            e_sel = '0;
        end else if (rate == '0) begin
            e_sel = ONE_Q15;
        end else if (dt_big || r_xbig || idx_big) begin
            e_sel = '0;
        end else begin
            e_sel = rom_data;
        end
    end

    assign q_rnd = 16'((prod + 64'd16384) >> 15);
    assign mag   = 34'((prod + 64'd32768) >> 16);

    // Round half away from zero already done on the magnitude; saturate here
    always_comb begin
        if (diff_neg) begin
            cur_sat = (mag > 34'h080000000) ? 32'h80000000 : 32'(-mag);
        end else begin
            cur_sat = (mag > 34'h07FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
        end
    end

    // Phase switch decision for the current word
    assign do_switch = r_open ? (inf || dt_gt_open)
                              : ((inf || dt_gt_refr) && (r_v > i_cfg.fire_level));

    // Working register write-back
    always_ff @(posedge i_clk) begin
        if (wb_go) begin
            case (i_ctrl.uc.wb)
                WB_LOAD: begin
                    r_now <= now_w;
                    r_dt  <= now_w - r_last;
                    r_v   <= i_membrane_level;
                end
                WB_X: begin
                    r_acc <= prod[39:0];
                end
                WB_IDX: begin
                    r_xbig <= r_acc[39:24] != '0;
                    r_acc  <= 40'((prod + 64'd8388608) >> 24);
                end
                WB_E: begin
                    r_e <= e_sel;
                end
                WB_Q: begin
                    r_q <= r_open ? (ONE_Q15 - q_rnd) : q_rnd;
                end
                WB_QQ: begin
                    r_acc <= prod[39:0];
                end
                WB_G: begin
                    r_acc <= 40'((prod + 64'd2097152) >> 22);
                end
                WB_CUR: begin
                    r_cur <= cur_sat;
                end
                default: begin
                end
            endcase
        end
    end

    // Gate state commits when the result word leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_has  <= 1'b0;
            r_gate <= '0;
            r_last <= '0;
        end else if (wb_go && (i_ctrl.uc.wb == WB_OUT) && do_switch) begin
            r_open <= !r_open;
            r_has  <= 1'b1;
            r_gate <= r_q;
            r_last <= r_now;
        end
    end

    assign o_current    = r_cur;
    assign o_gate       = r_q;
    assign o_phase_open = r_open;

endmodule

`default_nettype wire

### rtl/core/pulsed_potassium_channel_current_unit.sv
// Top level of the pulsed potassium channel current unit: config registers,
// channel handshakes and output register. Depends on ppkcc_pkg, ppkcc_seq, ppkcc_dp.
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Handshake                  | Word
// ---------+-----------+----------------------------+--------------------------------------
// input    | in        | i_in_valid / o_in_stall    | i_now_time, i_membrane_level
// output   | out       | o_out_valid / i_out_stall  | o_channel_current, o_gate_value,
//          |           |                            | o_phase_open
// config   | in        | APB psel/penable/pready    | paddr, pwdata, prdata
//
// A ten-step microcode program runs the exponent, gate and current math through one shared
// multiplier; the result is loaded into the output register at the program's final step.
// The next word is accepted once the program returns to its first step.
// A stalled output holds the final step until the output register frees up.
// Reset clears the program counter, gate state, config registers and output valid.

module pulsed_potassium_channel_current_unit #(
    parameter int TIME_WIDTH      = ppkcc_pkg::TIME_WIDTH_DEF,
    parameter int EXP_TABLE_DEPTH = ppkcc_pkg::EXP_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Input channel
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [31:0]        i_now_time,
    input  wire logic signed [15:0] i_membrane_level,
    // Output channel
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_channel_current,
    output logic [15:0]             o_gate_value,
    output logic                    o_phase_open,
    // Configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    import ppkcc_pkg::*;

    t_cfg       r_cfg;
    t_ctrl      ctrl;
    t_seq_stat  stat;
    logic       cfg_wr;
    logic [2:0] reg_idx;

    logic        r_out_valid;
    logic        n_out_valid;
    logic [31:0] r_out_cur;
    logic [15:0] r_out_gate;
    logic        r_out_phase;
    logic        out_load;
    logic [31:0] dp_cur;
    logic [15:0] dp_gate;
    logic        dp_phase;

    // Config writes
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_GAIN:       r_cfg.gain            <= pwdata[23:0];
                REG_RISE_RATE:  r_cfg.rise_rate       <= pwdata[15:0];
                REG_DECAY_RATE: r_cfg.decay_rate      <= pwdata[15:0];
                REG_FIRE_LEVEL: r_cfg.fire_level      <= pwdata[15:0];
                REG_OPEN_DUR:   r_cfg.open_duration   <= pwdata[23:0];
                REG_REFRACTORY: r_cfg.refractory_time <= pwdata[23:0];
                REG_REVERSAL:   r_cfg.reversal_level  <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // Config reads
    always_comb begin
        case (reg_idx)
            REG_GAIN:       prdata = 32'(r_cfg.gain);
            REG_RISE_RATE:  prdata = 32'(r_cfg.rise_rate);
            REG_DECAY_RATE: prdata = 32'(r_cfg.decay_rate);
            REG_FIRE_LEVEL: prdata = 32'(unsigned'(r_cfg.fire_level));
            REG_OPEN_DUR:   prdata = 32'(r_cfg.open_duration);
            REG_REFRACTORY: prdata = 32'(r_cfg.refractory_time);
            REG_REVERSAL:   prdata = 32'(unsigned'(r_cfg.reversal_level));
            default:        prdata = '0;
        endcase
    end

    // Sequencer status and input handshake
    assign stat.in_valid = i_in_valid;
    assign stat.out_busy = r_out_valid && i_out_stall;
    assign o_in_stall    = (ctrl.uc.jc != JC_HOLD_IN);

    ppkcc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    ppkcc_dp #(
        .TIME_WIDTH      (TIME_WIDTH),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (ctrl),
        .i_cfg            (r_cfg),
        .i_now_time       (i_now_time),
        .i_membrane_level (i_membrane_level),
        .o_current        (dp_cur),
        .o_gate           (dp_gate),
        .o_phase_open     (dp_phase)
    );

    // Output register
    assign out_load = (ctrl.uc.wb == WB_OUT) && ctrl.go;

    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_cur   <= dp_cur;
            r_out_gate  <= dp_gate;
            r_out_phase <= dp_phase;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_channel_current = r_out_cur;
    assign o_gate_value      = r_out_gate;
    assign o_phase_open      = r_out_phase;

endmodule

`default_nettype wire

### dv/pulsed_potassium_channel_current_unit_tb.sv
// Self-checking testbench for pulsed_potassium_channel_current_unit.
// A scoreboard class predicts gate value, phase and current for every accepted word.
// Depends on ppkcc_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module pulsed_potassium_channel_current_unit_tb;
    import ppkcc_pkg::*;

    localparam int LUT_DEPTH = EXP_DEPTH_DEF;

    // Address slot past the last register; writes there must be dropped
    localparam logic [2:0] REG_UNUSED = 3'd7;

    localparam logic signed [15:0] FIRE_BASE = -16'sd10240;

    typedef struct packed {
        logic signed [31:0] current;
        logic [15:0]        gate;
        logic               phase;
    } t_gate_result;

    typedef enum int {
        SET_BASE, SET_PEAK, SET_TYPICAL, SET_NO_RATE, SET_MAX, SET_WILD, SET_MIN
    } t_setting;

    // Gate/current predictor plus queue of awaited result words
    class channel_checker;
        logic [15:0]  exp_lut [LUT_DEPTH];
        t_cfg         cfg;
        logic         open_now;
        logic [15:0]  gate_origin;
        logic [31:0]  switch_stamp;
        logic         switched_once;
        t_gate_result awaited[$];
        int           errors;
        int           noted;
        int           checked;
        int           openings;

        function new();
            longint h, term, sum, a;
            h    = (longint'(16) << 30) / LUT_DEPTH;
            term = longint'(1) << 30;
            sum  = term;
            a    = term;
            // Taylor series of exp(-h) in Q30, then its powers
            for (int n = 1; n <= 24; n++) begin
                term = ((term * h) >> 30) / n;
                sum  = (n % 2 == 1) ? sum - term : sum + term;
            end
            if (sum < 0) sum = 0;
            if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
            for (int k = 0; k < LUT_DEPTH; k++) begin
                exp_lut[k] = 16'((a + (1 << 14)) >> 15);
                a = (a * sum + (longint'(1) << 29)) >> 30;
            end
            cfg           = '0;
            open_now      = 1'b0;
            gate_origin   = '0;
            switch_stamp  = '0;
            switched_once = 1'b0;
            errors        = 0;
            noted         = 0;
            checked       = 0;
            openings      = 0;
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 40)
                $display("MISMATCH @%0t: %s", $time, msg);
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                REG_GAIN:       cfg.gain            = data[23:0];
                REG_RISE_RATE:  cfg.rise_rate       = data[15:0];
                REG_DECAY_RATE: cfg.decay_rate      = data[15:0];
                REG_FIRE_LEVEL: cfg.fire_level      = data[15:0];
                REG_OPEN_DUR:   cfg.open_duration   = data[23:0];
                REG_REFRACTORY: cfg.refractory_time = data[23:0];
                REG_REVERSAL:   cfg.reversal_level  = data[15:0];
                default: ;
            endcase
        endfunction

        // exp(-rate*dt) in Q1.15 via table; never-switched counts as infinite dt
        function logic [15:0] decay_factor(logic [15:0] rate, logic [31:0] dt, logic never);
            longint unsigned x, idx;
            if (never) return '0;
            if (rate == 0) return ONE_Q15;
            if (dt >= 32'h0100_0000) return '0;
            x = longint'(rate) * longint'(dt);
            if (x >= 64'h0100_0000) return '0;
            idx = (x * LUT_DEPTH + 64'h0080_0000) >> 24;
            if (idx >= LUT_DEPTH) return '0;
            return exp_lut[idx];
        endfunction

        // Predict the result of one accepted word and advance the gate state
        function void note_word(logic [31:0] now, logic signed [15:0] level);
            logic [31:0]     dt;
            logic            never;
            logic [15:0]     q0, e, q;
            longint unsigned gq, mag;
            longint          diff, cur;
            t_gate_result    r;
            dt    = now - switch_stamp;
            never = !switched_once;
            q0    = (gate_origin > ONE_Q15) ? ONE_Q15 : gate_origin;
            if (!open_now) begin
                e = decay_factor(cfg.decay_rate, dt, never);
                q = 16'((longint'(q0) * longint'(e) + 64'h4000) >> 15);
            end else begin
                e = decay_factor(cfg.rise_rate, dt, never);
                q = ONE_Q15 - 16'((longint'(ONE_Q15 - q0) * longint'(e) + 64'h4000) >> 15);
            end
            gq   = (longint'(cfg.gain) * longint'(q) * longint'(q) + 64'h20_0000) >> 22;
            diff = longint'($signed(cfg.reversal_level)) - longint'(level);
            mag  = (diff < 0) ? -diff : diff;
            mag  = (gq * mag + 64'h8000) >> 16;
            // Round half away from zero, then saturate to Q16.16
            if (diff < 0)
                cur = (mag > 64'h8000_0000) ? -longint'(64'h8000_0000) : -longint'(mag);
            else
                cur = (mag > 64'h7FFF_FFFF) ? longint'(64'h7FFF_FFFF) : longint'(mag);
            r.current = cur[31:0];
            r.gate    = q;
            r.phase   = open_now;
            awaited.push_back(r);
            noted++;

            // Phase switch after the current is taken
            if (open_now) begin
                if (never || dt > cfg.open_duration) begin
                    open_now      = 1'b0;
                    switch_stamp  = now;
                    gate_origin   = q;
                    switched_once = 1'b1;
                end
            end else if ((never || dt > cfg.refractory_time) &&
                         level > $signed(cfg.fire_level)) begin
                open_now      = 1'b1;
                switch_stamp  = now;
                gate_origin   = q;
                switched_once = 1'b1;
                openings++;
            end
        endfunction

        function void check_word(logic signed [31:0] current, logic [15:0] gate, logic phase);
            t_gate_result r;
            if (awaited.size() == 0) begin
                report("result word with nothing awaited");
                return;
            end
            r = awaited.pop_front();
            checked++;
            if (current !== r.current)
                report($sformatf("current %0d, predicted %0d", current, r.current));
            if (gate !== r.gate)
                report($sformatf("gate %0d, predicted %0d", gate, r.gate));
            if (phase !== r.phase)
                report($sformatf("phase %0b, predicted %0b", phase, r.phase));
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n          = 1'b0;
    logic               i_in_valid       = 1'b0;
    logic               o_in_stall;
    logic [31:0]        i_now_time       = '0;
    logic signed [15:0] i_membrane_level = '0;
    logic               o_out_valid;
    logic               i_out_stall      = 1'b0;
    logic signed [31:0] o_channel_current;
    logic [15:0]        o_gate_value;
    logic               o_phase_open;
    logic               psel             = 1'b0;
    logic               penable          = 1'b0;
    logic               pwrite           = 1'b0;
    logic [4:0]         paddr            = '0;
    logic [31:0]        pwdata           = '0;
    logic [31:0]        prdata;
    logic               pready;

    int          in_idle_pct   = 0;
    int          out_stall_pct = 0;
    int          settings_used = 0;
    logic [31:0] clock_now     = '0;

    channel_checker sb;

    pulsed_potassium_channel_current_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_now_time        (i_now_time),
        .i_membrane_level  (i_membrane_level),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_channel_current (o_channel_current),
        .o_gate_value      (o_gate_value),
        .o_phase_open      (o_phase_open),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Result side: check accepted words, then pick next cycle's stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_word(o_channel_current, o_gate_value, o_phase_open);
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // Register write: setup phase, access phase held until pready, then back to idle
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic write_setting(input t_setting kind);
        logic [31:0] vals [7];
        vals[REG_GAIN]       = $urandom_range(32'h4_0000);
        vals[REG_RISE_RATE]  = $urandom_range(16384, 256);
        vals[REG_DECAY_RATE] = $urandom_range(16384, 256);
        vals[REG_FIRE_LEVEL] = 32'(-int'($urandom_range(60 * 256, 20 * 256)));
        vals[REG_OPEN_DUR]   = $urandom_range(600);
        vals[REG_REFRACTORY] = $urandom_range(600);
        vals[REG_REVERSAL]   = 32'(int'($urandom_range(25600)) - 19200);
        case (kind)
            SET_BASE: begin
                vals[REG_GAIN]       = 32'h0001_0000;
                vals[REG_RISE_RATE]  = 32'd4096;
                vals[REG_DECAY_RATE] = 32'd2048;
                vals[REG_FIRE_LEVEL] = 32'(FIRE_BASE);
                vals[REG_OPEN_DUR]   = 32'd64;
                vals[REG_REFRACTORY] = 32'd128;
                vals[REG_REVERSAL]   = 32'(-23040);
            end
            SET_PEAK, SET_MAX: begin
                vals[REG_GAIN]       = 32'h00FF_FFFF;
                vals[REG_RISE_RATE]  = 32'h0000_FFFF;
                vals[REG_DECAY_RATE] = 32'h0000_FFFF;
                vals[REG_FIRE_LEVEL] = (kind == SET_PEAK) ? 32'h0000_8000 : 32'h0000_7FFF;
                vals[REG_OPEN_DUR]   = 32'h00FF_FFFF;
                vals[REG_REFRACTORY] = 32'h00FF_FFFF;
                vals[REG_REVERSAL]   = 32'h0000_7FFF;
            end
            SET_NO_RATE: begin
                vals[REG_RISE_RATE]  = '0;
                vals[REG_DECAY_RATE] = '0;
            end
            SET_WILD: begin
                for (int i = 0; i <= REG_REVERSAL; i++) vals[i] = $urandom;
            end
            SET_MIN: begin
                vals[REG_GAIN]       = 32'd1;
                vals[REG_RISE_RATE]  = 32'd1;
                vals[REG_DECAY_RATE] = 32'd1;
                vals[REG_FIRE_LEVEL] = 32'hFFFF_8000;
                vals[REG_OPEN_DUR]   = '0;
                vals[REG_REFRACTORY] = '0;
                vals[REG_REVERSAL]   = 32'hFFFF_8000;
            end
            default: ;
        endcase
        for (int i = 0; i <= REG_REVERSAL; i++) reg_write(3'(i), vals[i]);
        settings_used++;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
            1: begin in_idle_pct = 69; out_stall_pct = 0;  end
            2: begin in_idle_pct = 0;  out_stall_pct = 69; end
            default: begin in_idle_pct = 26; out_stall_pct = 26; end
        endcase
    endtask

    // Offer one word, idling first at random; returns after the accepting edge
    task automatic send_word(input logic [31:0] stamp, input logic signed [15:0] level);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_now_time       <= stamp;
        i_membrane_level <= level;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_word(stamp, level);
    endtask

    // Time mostly creeps forward; voltage mostly hovers around the firing level
    task automatic send_random();
        int pick, lvl;
        pick = $urandom_range(99);
        if (pick < 70)      clock_now += $urandom_range(64);
        else if (pick < 90) clock_now += $urandom_range(1024);
        else if (pick < 97) clock_now += $urandom_range(32'h0200_0000);
        else                clock_now = $urandom;
        pick = $urandom_range(99);
        if (pick < 45)
            lvl = int'($signed(sb.cfg.fire_level)) + int'($urandom_range(1024)) - 512;
        else if (pick < 70)
            lvl = int'($signed(16'($urandom)));
        else
            lvl = int'($signed(sb.cfg.fire_level)) - int'($urandom_range(8192));
        if (lvl > 32767)  lvl = 32767;
        if (lvl < -32768) lvl = -32768;
        send_word(clock_now, 16'(lvl));
    endtask

    // Let the block go idle: every predicted word back, then a short margin
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    initial begin
        t_setting plan [6];
        plan = '{SET_TYPICAL, SET_NO_RATE, SET_MAX, SET_WILD, SET_TYPICAL, SET_MIN};
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: first word sees infinite dt
        send_word(32'd0, 16'sd0);
        send_word(32'd5, 16'sd1);
        send_word(32'd7, -16'sd32768);
        drain();

        // Baseline settings: refractory, open time, threshold edge, time wrap
        write_setting(SET_BASE);
        reg_write(REG_UNUSED, 32'hDEAD_BEEF);
        send_word(32'd100, -16'sd32768);
        send_word(32'd200, 16'sd32767);
        send_word(32'd210, 16'sd0);
        send_word(32'd264, 16'sd0);
        send_word(32'd265, 16'sd0);
        send_word(32'd300, 16'sd32767);
        send_word(32'd394, FIRE_BASE);
        send_word(32'd395, FIRE_BASE + 16'sd1);
        send_word(32'hFFFF_FFF0, -16'sd32768);
        send_word(32'hFFFF_FFFF, 16'sd32767);
        send_word(32'h0000_0100, 16'sd32767);
        send_word(32'h0000_0100, -16'sd32768);
        send_word(32'h0000_0180, 16'sd0);
        drain();

        // Largest gain: positive then negative saturation
        write_setting(SET_PEAK);
        clock_now = 32'h0300_0180;
        send_word(clock_now, 16'sd32767);
        clock_now += 32'h0200_0000;
        send_word(clock_now, -16'sd32768);
        drain();
        reg_write(REG_REVERSAL, 32'hFFFF_8000);
        send_word(clock_now, 16'sd32767);
        send_word(clock_now + 32'd1, 16'sd32767);
        drain();

        // Random phases, each with freshly written settings and one of four idle patterns
        for (int p = 0; p < 6; p++) begin
            write_setting(plan[p]);
            set_idling(p % 4);
            repeat (260) send_random();
            drain();
        end

        $display("Covered %0d words (%0d checked, %0d gate openings) under %0d settings,",
                 sb.noted, sb.checked, sb.openings, settings_used);
        $display("with idle sender, stalled receiver, both and neither.");
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #1_000_000;
        $display("Timed out with %0d words still awaited", sb.outstanding());
        $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/core/ppkcc_pkg.sv
rtl/core/ppkcc_exp_rom.sv
rtl/core/ppkcc_seq.sv
rtl/core/ppkcc_dp.sv
rtl/core/pulsed_potassium_channel_current_unit.sv
dv/pulsed_potassium_channel_current_unit_tb.sv
